// ===== rtl/core/spp_pkg.sv =====
package spp_pkg;

	localparam int SYM_W  = 8;
	localparam int MODE_W = 16;

	localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
	localparam logic [SYM_W-1:0] CH_U     = 8'h75;
	localparam logic [SYM_W-1:0] CH_G     = 8'h67;
	localparam logic [SYM_W-1:0] CH_O     = 8'h6f;
	localparam logic [SYM_W-1:0] CH_A     = 8'h61;
	localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2b;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2d;
	localparam logic [SYM_W-1:0] CH_EQ    = 8'h3d;
	localparam logic [SYM_W-1:0] CH_R     = 8'h72;
	localparam logic [SYM_W-1:0] CH_W     = 8'h77;
	localparam logic [SYM_W-1:0] CH_X     = 8'h78;
	localparam logic [SYM_W-1:0] CH_COMMA = 8'h2c;
	localparam logic [SYM_W-1:0] CH_SEMI  = 8'h3b;

	localparam logic [1:0] OP_NONE   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_ASSIGN = 2'd3;

	typedef struct packed {
		logic              at_start;
		logic              in_rights;
		logic [2:0]        classes;
		logic [2:0]        rights;
		logic [1:0]        op;
		logic [MODE_W-1:0] mode;
		logic              err;
	} parse_state_t;

	typedef struct packed {
		logic              valid;
		logic [MODE_W-1:0] mode;
		logic              bad;
	} parse_result_t;

	localparam parse_state_t PARSE_RESET = '{
		at_start:  1'b1,
		in_rights: 1'b0,
		classes:   3'd0,
		rights:    3'd0,
		op:        OP_NONE,
		mode:      '0,
		err:       1'b0
	};

endpackage

// ===== rtl/core/spp_step.sv =====
module spp_step
	import spp_pkg::*;
(
	input  parse_state_t        st,
	input  logic [SYM_W-1:0]    symbol,
	input  logic [MODE_W-1:0]   start_mode,
	output parse_state_t        nxt,
	output parse_result_t       res
);

	function automatic logic [MODE_W-1:0] who_mask(input logic [2:0] t);
		logic [MODE_W-1:0] m;
		m = '0;
		if (t[2]) m[8:6] = 3'b111;
		if (t[1]) m[5:3] = 3'b111;
		if (t[0]) m[2:0] = 3'b111;
		return m;
	endfunction

	function automatic logic [MODE_W-1:0] rights_mask(input logic [2:0] r);
		logic [MODE_W-1:0] m;
		m = '0;
		if (r[2]) m[8:0] = m[8:0] | 9'o444;
		if (r[1]) m[8:0] = m[8:0] | 9'o222;
		if (r[0]) m[8:0] = m[8:0] | 9'o111;
		return m;
	endfunction

	function automatic logic [MODE_W-1:0] apply_clause(input parse_state_t s);
		logic [MODE_W-1:0] who;
		logic [MODE_W-1:0] sel;
		logic [MODE_W-1:0] m;
		who = who_mask(s.classes);
		sel = who & rights_mask(s.rights);
		case (s.op)
			OP_ADD:    m = s.mode | sel;
			OP_REMOVE: m = s.mode & ~sel;
			OP_ASSIGN: m = (s.mode & ~who) | sel;
			default:   m = s.mode;
		endcase
		return m;
	endfunction

	parse_state_t base;

	always_comb begin
		base = st;
		if (st.at_start) begin
			base = PARSE_RESET;
			base.at_start = 1'b0;
			base.mode = start_mode;
		end

		nxt = base;
		res.valid = 1'b0;
		res.mode = base.mode;
		res.bad = base.err;

		if (symbol == CH_NUL) begin
			if (base.in_rights) begin
				nxt.mode = apply_clause(base);
			end
			nxt.in_rights = 1'b0;
			nxt.classes = 3'd0;
			nxt.rights = 3'd0;
			nxt.op = OP_NONE;
			nxt.at_start = 1'b1;
			res.valid = 1'b1;
			res.mode = nxt.mode;
		end else if (!base.in_rights) begin
			case (symbol)
				CH_PLUS: begin
					nxt.op = OP_ADD;
					nxt.in_rights = 1'b1;
					nxt.rights = 3'd0;
				end
				CH_MINUS: begin
					nxt.op = OP_REMOVE;
					nxt.in_rights = 1'b1;
					nxt.rights = 3'd0;
				end
				CH_EQ: begin
					nxt.op = OP_ASSIGN;
					nxt.in_rights = 1'b1;
					nxt.rights = 3'd0;
				end
				CH_U:    nxt.classes = base.classes | 3'b100;
				CH_G:    nxt.classes = base.classes | 3'b010;
				CH_O:    nxt.classes = base.classes | 3'b001;
				CH_A:    nxt.classes = 3'b111;
				default: nxt.err = 1'b1;
			endcase
		end else begin
			case (symbol)
				CH_COMMA, CH_SEMI: begin
					nxt.mode = apply_clause(base);
					nxt.in_rights = 1'b0;
					nxt.classes = 3'd0;
					nxt.rights = 3'd0;
					nxt.op = OP_NONE;
				end
				CH_R:    nxt.rights = base.rights | 3'b100;
				CH_W:    nxt.rights = base.rights | 3'b010;
				CH_X:    nxt.rights = base.rights | 3'b001;
				default: nxt.err = 1'b1;
			endcase
		end
	end

endmodule

// ===== rtl/core/symbolic_permission_parser.sv =====
// Symbolic permission parser: feed a chmod-style clause string one character
// per beat on the input channel (symbol, start_mode under in_valid/in_stall).
// A NUL character ends the string. start_mode is sampled only with the first
// character of each string. For every NUL the block returns one beat on the
// output channel (new_mode, bad_input under out_valid/out_stall); all other
// characters return nothing.
// A character accepted on the input channel lands in the input register; it is
// parsed from there into the parser state register and, if it was a NUL, the
// result loads into the output register together with the state update.
// Throughput: one character per cycle while in_stall stays low.
// Reset (arst_n low, asynchronous) empties both registers and returns the
// parser to the start of a string.
// When the receiver stalls, the result stays in the output register; further
// characters keep flowing until a second NUL reaches the input register, which
// then holds and in_stall rises until the waiting result is taken.
module symbolic_permission_parser
	import spp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [SYM_W-1:0]  symbol,
	input  logic [MODE_W-1:0] start_mode,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [MODE_W-1:0] new_mode,
	output logic              bad_input
);

	// input register
	logic              valid_s1;
	logic [SYM_W-1:0]  symbol_s1;
	logic [MODE_W-1:0] mode_s1;

	// parser state and the next state computed from the held character
	parse_state_t  state_q;
	parse_state_t  state_next;
	parse_result_t step_res;

	logic blocked;
	logic fire;

	// a terminator may only go ahead when the result slot is free or draining
	assign blocked  = step_res.valid && out_valid && out_stall;
	assign fire     = valid_s1 && !blocked;
	assign in_stall = valid_s1 && blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// capture the beat; hold it while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			symbol_s1 <= symbol;
			mode_s1   <= start_mode;
		end
	end

	spp_step u_step (
		.st         (state_q),
		.symbol     (symbol_s1),
		.start_mode (mode_s1),
		.nxt        (state_next),
		.res        (step_res)
	);

	// advance the parser once per character that goes through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_RESET;
		end else if (fire) begin
			state_q <= state_next;
		end
	end

	// result register: load on a terminator, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire && step_res.valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && step_res.valid) begin
			new_mode  <= step_res.mode;
			bad_input <= step_res.bad;
		end
	end

`ifndef SYNTH
	a_stall_needs_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("input stalled without a waiting result");

	a_result_from_terminator: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(fire && symbol_s1 == CH_NUL))
		else $error("result appeared without a terminator");

	a_restart_after_terminator: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && symbol_s1 == CH_NUL) |=> (state_q.at_start && !state_q.in_rights))
		else $error("parser not back at string start after terminator");

	a_held_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(new_mode)
			&& $stable(bad_input)))
		else $error("stalled result changed");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the symbolic permission parser.
// A queue of characters feeds a clocked driver. A clocked monitor predicts
// every accepted character and checks every result beat against the oldest
// predicted mode.
module testbench;
	import spp_pkg::*;

	// One character beat on the input channel. drain makes the driver hold this
	// beat back until every predicted result has come out.
	typedef struct {
		logic [SYM_W-1:0]  sym;
		logic [MODE_W-1:0] mode;
		bit                drain;
	} char_beat_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic              bad;
	} mode_result_t;

	localparam int RANDOM_CHARS = 1300;

	// Character pools for building well-formed clauses
	localparam logic [4*SYM_W-1:0] WHO_SET   = {CH_U, CH_G, CH_O, CH_A};
	localparam logic [3*SYM_W-1:0] SIGN_SET  = {CH_PLUS, CH_MINUS, CH_EQ};
	localparam logic [3*SYM_W-1:0] RIGHT_SET = {CH_R, CH_W, CH_X};

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic [SYM_W-1:0]  symbol     = '0;
	logic [MODE_W-1:0] start_mode = '0;
	logic              out_stall  = 1'b0;
	logic              in_stall;
	logic              out_valid;
	logic [MODE_W-1:0] new_mode;
	logic              bad_input;

	char_beat_t   chars_pending[$];
	mode_result_t results_due[$];

	// Parser state as the bench sees it
	bit                fresh     = 1'b1;
	bit                sign_seen = 1'b0;
	logic [2:0]        who_bits  = '0;
	logic [2:0]        perm_bits = '0;
	logic [1:0]        op_code   = OP_NONE;
	logic [MODE_W-1:0] mode_acc  = '0;
	bit                err_flag  = 1'b0;

	// Handshake bookkeeping, sampled at the rising edge
	bit char_taken = 1'b0;
	bit mode_taken = 1'b0;
	int chars_total = 0;
	int chars_taken = 0;
	int fail_count  = 0;

	// Idle control for both sides
	int unsigned send_wait = 0;
	int unsigned recv_wait = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;

	// String builder state
	bit                str_head  = 1'b0;
	logic [MODE_W-1:0] str_mode  = '0;
	bit                str_drain = 1'b0;

	symbolic_permission_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.symbol     (symbol),
		.start_mode (start_mode),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.new_mode   (new_mode),
		.bad_input  (bad_input)
	);

	always #5 clk = ~clk;

	// Apply the finished clause to the mode under construction: the who-list
	// picks whole triads, the rights pick one bit inside every triad.
	function automatic void close_clause();
		logic [MODE_W-1:0] who;
		logic [MODE_W-1:0] sel;
		who = {7'b0, {3{who_bits[2]}}, {3{who_bits[1]}}, {3{who_bits[0]}}};
		sel = who & {7'b0, perm_bits, perm_bits, perm_bits};
		case (op_code)
			OP_ADD:    mode_acc = mode_acc | sel;
			OP_REMOVE: mode_acc = mode_acc & ~sel;
			OP_ASSIGN: mode_acc = (mode_acc & ~who) | sel;
			default:   ;
		endcase
		sign_seen = 1'b0;
		who_bits  = '0;
		perm_bits = '0;
		op_code   = OP_NONE;
	endfunction

	// Advance the predicted parser by one accepted character; queue a result
	// at the terminator.
	task automatic parse_char(input logic [SYM_W-1:0] c, input logic [MODE_W-1:0] m);
		if (fresh) begin
			mode_acc  = m;
			sign_seen = 1'b0;
			who_bits  = '0;
			perm_bits = '0;
			op_code   = OP_NONE;
			err_flag  = 1'b0;
			fresh     = 1'b0;
		end
		if (c == CH_NUL) begin
			// a dangling who-list without a sign is simply dropped
			if (sign_seen)
				close_clause();
			sign_seen = 1'b0;
			who_bits  = '0;
			perm_bits = '0;
			op_code   = OP_NONE;
			results_due.push_back('{mode: mode_acc, bad: err_flag});
			fresh = 1'b1;
		end else if (!sign_seen) begin
			case (c)
				CH_PLUS: begin
					op_code = OP_ADD; sign_seen = 1'b1; perm_bits = '0;
				end
				CH_MINUS: begin
					op_code = OP_REMOVE; sign_seen = 1'b1; perm_bits = '0;
				end
				CH_EQ: begin
					op_code = OP_ASSIGN; sign_seen = 1'b1; perm_bits = '0;
				end
				CH_U:    who_bits = who_bits | 3'b100;
				CH_G:    who_bits = who_bits | 3'b010;
				CH_O:    who_bits = who_bits | 3'b001;
				CH_A:    who_bits = 3'b111;
				// separators land here too: no clause is open yet
				default: err_flag = 1'b1;
			endcase
		end else begin
			case (c)
				CH_COMMA, CH_SEMI: close_clause();
				CH_R:    perm_bits = perm_bits | 3'b100;
				CH_W:    perm_bits = perm_bits | 3'b010;
				CH_X:    perm_bits = perm_bits | 3'b001;
				default: err_flag = 1'b1;
			endcase
		end
	endtask

	// Queue one character; only the first one of a string carries the real
	// start mode, the rest carry junk the block must ignore.
	task automatic push_char(input logic [SYM_W-1:0] c);
		char_beat_t b;
		b.sym   = c;
		b.mode  = str_head ? str_mode : MODE_W'($urandom);
		b.drain = str_head && str_drain;
		str_head = 1'b0;
		chars_pending.push_back(b);
	endtask

	task automatic push_text(input string s, input logic [MODE_W-1:0] m);
		str_head  = 1'b1;
		str_mode  = m;
		str_drain = 1'b0;
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
		push_char(CH_NUL);
	endtask

	// Driver: change inputs on the falling edge. Hold a beat until it is taken,
	// then idle for the drawn number of cycles before the next one.
	always @(negedge clk) begin
		char_beat_t beat;
		if (arst_n && (!in_valid || char_taken)) begin
			if (send_wait != 0) begin
				in_valid  <= 1'b0;
				send_wait <= send_wait - 1;
			end else if (chars_pending.size() != 0 &&
					!(chars_pending[0].drain && results_due.size() != 0)) begin
				beat = chars_pending.pop_front();
				symbol     <= beat.sym;
				start_mode <= beat.mode;
				in_valid   <= 1'b1;
				// flip between bursts and idling now and then
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
				send_wait <= send_calm ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: draw a stall length per result, count it down only while a
	// result is actually waiting.
	always @(negedge clk) begin
		int unsigned hold;
		if (arst_n) begin
			hold = recv_wait;
			if (mode_taken) begin
				if ($urandom_range(0, 29) == 0)
					recv_calm = !recv_calm;
				hold = recv_calm ? 0 : $urandom_range(0, 4);
			end
			out_stall <= (hold != 0);
			if (hold != 0 && out_valid)
				hold = hold - 1;
			recv_wait <= hold;
		end
	end

	// Monitor: sample both channels on the rising edge, predict accepted
	// characters and check result beats in order.
	always @(posedge clk) begin
		mode_result_t want;
		if (arst_n) begin
			char_taken <= in_valid && !in_stall;
			mode_taken <= out_valid && !out_stall;
			if (in_valid && !in_stall) begin
				parse_char(symbol, start_mode);
				chars_taken++;
			end
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$display("%0t: result beat with none pending: new_mode %h bad_input %b",
						$time, new_mode, bad_input);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					if (new_mode !== want.mode) begin
						$display("%0t: new_mode expected %h, got %h",
							$time, want.mode, new_mode);
						fail_count++;
					end
					if (bad_input !== want.bad) begin
						$display("%0t: bad_input expected %b, got %b",
							$time, want.bad, bad_input);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		int base;
		int shape;
		int n_clauses;
		int n_items;
		bit broken;
		bit no_sign;

		// Directed strings
		push_text("", 16'hffff);                    // empty string keeps the mode
		push_text("a=", 16'hffff);                  // assign nothing clears all triads
		push_text("+x", 16'h0000);                  // empty who-list does nothing
		push_text("ug-wx,o+r;go", 16'h5a5a);        // trailing who-list is dropped
		push_text(",\377o=\200r", 16'habcd);        // junk before and after the sign

		// Random strings: mostly well-formed clauses, some junk and broken ones
		base = chars_pending.size();
		for (int k = 0; chars_pending.size() < base + RANDOM_CHARS; k++) begin
			str_head = 1'b1;
			case ($urandom_range(0, 7))
				0:       str_mode = '0;
				1:       str_mode = '1;
				default: str_mode = MODE_W'($urandom);
			endcase
			// pause the sender for a full drain every so often
			str_drain = (k % 60 == 0);
			shape = $urandom_range(0, 11);
			if (shape >= 2 && shape <= 3) begin
				// pure noise, any byte but the terminator
				n_items = $urandom_range(1, 6);
				for (int i = 0; i < n_items; i++)
					push_char(SYM_W'($urandom_range(1, 255)));
			end else if (shape >= 4) begin
				broken = (shape == 4);
				n_clauses = $urandom_range(1, 4);
				for (int c = 0; c < n_clauses; c++) begin
					if (c > 0)
						push_char($urandom_range(0, 1) ? CH_COMMA : CH_SEMI);
					n_items = $urandom_range(0, 3);
					for (int i = 0; i < n_items; i++)
						push_char(WHO_SET[SYM_W*$urandom_range(0, 3) +: SYM_W]);
					no_sign = broken && (c == n_clauses - 1);
					if (!no_sign)
						push_char(SIGN_SET[SYM_W*$urandom_range(0, 2) +: SYM_W]);
					if (!no_sign || $urandom_range(0, 1)) begin
						n_items = $urandom_range(0, 3);
						for (int i = 0; i < n_items; i++)
							push_char(RIGHT_SET[SYM_W*$urandom_range(0, 2) +: SYM_W]);
					end
					if ($urandom_range(0, 19) == 0)
						push_char(SYM_W'($urandom_range(1, 255)));
				end
			end
			// shapes 0 and 1 leave the string empty, giving runs of terminators
			push_char(CH_NUL);
		end
		chars_total = chars_pending.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: every beat in, every result out, then a quiet wait
		wait (chars_taken == chars_total);
		for (int w = 0; w < 200 && results_due.size() != 0; w++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, results_due.size());
			fail_count++;
		end

		if (fail_count == 0)
			$display("** symbolic_permission_parser: PASSED **");
		else
			$display("** symbolic_permission_parser: FAILED **");
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin
		#2_000_000;
		$display("** symbolic_permission_parser: FAILED **");
		$finish;
	end

endmodule

// ===== symbolic_permission_parser.f =====
rtl/core/spp_pkg.sv
rtl/core/spp_step.sv
rtl/core/symbolic_permission_parser.sv
verif/testbench.sv
